// ===== design/assert_macros.svh =====
// Assertion macros shared by the channel-width parser RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== design/wiecw_pkg.sv =====
// Package for the information-element channel-width parser.
// Holds element ids, width codes and the captured-field struct; no dependencies.
package wiecw_pkg;

   localparam logic [7:0] ID_HT_OP   = 8'd61;
   localparam logic [7:0] ID_VHT_CAP = 8'd191;
   localparam logic [7:0] ID_VHT_OP  = 8'd192;
   localparam logic [7:0] ID_HE_EXT  = 8'd255;
   localparam logic [7:0] EXT_HE_CAP = 8'd35;
   localparam logic [7:0] SPAN_80P80 = 8'd16;
   localparam logic [7:0] SPAN_160   = 8'd8;

   localparam logic [2:0] CW_20    = 3'd0;
   localparam logic [2:0] CW_40    = 3'd1;
   localparam logic [2:0] CW_40_UP = 3'd2;
   localparam logic [2:0] CW_40_DN = 3'd3;
   localparam logic [2:0] CW_80    = 3'd4;
   localparam logic [2:0] CW_160   = 3'd5;
   localparam logic [2:0] CW_80P80 = 3'd6;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_HT   = 2'd1;
   localparam logic [1:0] MODE_VHT  = 2'd2;
   localparam logic [1:0] MODE_HE   = 2'd3;

   typedef struct packed {
      logic       ht_seen;
      logic       vht_seen;
      logic       he_seen;
      logic [1:0] sec_offset;
      logic [7:0] ccfs2_value;
      logic [1:0] supp_width_set;
      logic [1:0] ext_nss_support;
      logic [7:0] vht_op_width;
      logic [7:0] center_seg0;
      logic [7:0] center_seg1;
      logic [1:0] he_width_set;
   } cap_type;

endpackage

// ===== design/wiecw_tracker.sv =====
// Element walker: follows id, length and position of each element and
// captures the width-related fields. Depends on wiecw_pkg.
module wiecw_tracker
   import wiecw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] ie_byte,
   input  logic       last_byte,
   output cap_type    cap_next
);

   logic [7:0] elem_id_ff, elem_id_in;
   logic [7:0] elem_len_ff, elem_len_in;
   logic [8:0] byte_pos_ff, byte_pos_in;
   cap_type    cap_ff, cap_in;

   always_comb begin
      elem_id_in  = elem_id_ff;
      elem_len_in = elem_len_ff;
      byte_pos_in = byte_pos_ff;
      cap_in      = cap_ff;
      priority if (byte_pos_ff == 9'd0) begin
         elem_id_in = ie_byte;
         if (ie_byte == ID_HT_OP) cap_in.ht_seen = 1'b1;
         if (ie_byte == ID_VHT_CAP || ie_byte == ID_VHT_OP) cap_in.vht_seen = 1'b1;
         byte_pos_in = 9'd1;
      end else if (byte_pos_ff == 9'd1) begin
         elem_len_in = ie_byte;
         byte_pos_in = (ie_byte == 8'd0) ? 9'd0 : 9'd2;
      end else begin
         unique case (elem_id_ff)
            ID_HT_OP: begin
               if (byte_pos_ff == 9'd3) cap_in.sec_offset = ie_byte[1:0];
               else if (byte_pos_ff == 9'd4) cap_in.ccfs2_value[2:0] = ie_byte[7:5];
               else if (byte_pos_ff == 9'd5) cap_in.ccfs2_value[7:3] = ie_byte[4:0];
            end
            ID_VHT_CAP: begin
               if (byte_pos_ff == 9'd2) cap_in.supp_width_set = ie_byte[3:2];
               else if (byte_pos_ff == 9'd5) cap_in.ext_nss_support = ie_byte[7:6];
            end
            ID_VHT_OP: begin
               if (byte_pos_ff == 9'd2) cap_in.vht_op_width = ie_byte;
               else if (byte_pos_ff == 9'd3) cap_in.center_seg0 = ie_byte;
               else if (byte_pos_ff == 9'd4) cap_in.center_seg1 = ie_byte;
            end
            ID_HE_EXT: begin
               if (byte_pos_ff == 9'd2) begin
                  if (ie_byte == EXT_HE_CAP) cap_in.he_seen = 1'b1;
                  else elem_id_in = 8'd0;
               end else if (byte_pos_ff == 9'd9) begin
                  cap_in.he_width_set = ie_byte[4:3];
               end
            end
            default: begin
            end
         endcase
         byte_pos_in = (byte_pos_ff >= ({1'b0, elem_len_ff} + 9'd1)) ? 9'd0
                                                                     : byte_pos_ff + 9'd1;
      end
   end

   assign cap_next = cap_in;

   // drop all state after the last byte so the next list starts clean
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         elem_id_ff  <= '0;
         elem_len_ff <= '0;
         byte_pos_ff <= '0;
         cap_ff      <= '0;
      end else if (step) begin
         elem_id_ff  <= elem_id_in;
         elem_len_ff <= elem_len_in;
         byte_pos_ff <= byte_pos_in;
         cap_ff      <= cap_in;
      end
   end

endmodule

// ===== design/wiecw_decide.sv =====
// Width decision: picks HE, VHT or HT width from the captured fields and
// promotes 80 MHz to 160 or 80+80. Depends on wiecw_pkg.
module wiecw_decide
   import wiecw_pkg::*;
(
   input  cap_type    cap,
   output logic [2:0] chan_width,
   output logic [1:0] mode_seen
);

   logic [2:0] ht_cw, vht_cw, base_cw, promo_cw;
   logic [3:0] nss_map;
   logic       rev, ccf, ccf160, ccf8080;
   logic [7:0] d_seg, d_ccf;

   always_comb begin
      unique case (cap.sec_offset)
         2'd0:    ht_cw = CW_20;
         2'd1:    ht_cw = CW_40_UP;
         2'd3:    ht_cw = CW_40_DN;
         default: ht_cw = CW_40;
      endcase

      priority if (cap.vht_op_width == 8'd0) vht_cw = ht_cw;
      else if (cap.vht_op_width == 8'd1) vht_cw = CW_80;
      else if (cap.vht_op_width == 8'd2) vht_cw = CW_160;
      else vht_cw = CW_80P80;

      priority if (cap.he_seen) begin
         mode_seen = MODE_HE;
         unique case (cap.he_width_set)
            2'd0:    base_cw = vht_cw;
            2'd1:    base_cw = CW_160;
            2'd3:    base_cw = CW_80P80;
            default: base_cw = CW_20;
         endcase
      end else if (cap.vht_seen) begin
         mode_seen = MODE_VHT;
         base_cw   = vht_cw;
      end else if (cap.ht_seen) begin
         mode_seen = MODE_HT;
         base_cw   = ht_cw;
      end else begin
         mode_seen = MODE_NONE;
         base_cw   = CW_20;
      end
   end

   always_comb begin
      nss_map = {cap.supp_width_set, cap.ext_nss_support};
      rev     = (cap.vht_op_width == 8'd1) && (cap.center_seg1 != 8'd0);
      ccf     = (cap.vht_op_width == 8'd1) && (cap.ccfs2_value != 8'd0);
      d_seg   = (cap.center_seg1 >= cap.center_seg0) ? cap.center_seg1 - cap.center_seg0
                                                     : cap.center_seg0 - cap.center_seg1;
      d_ccf   = (cap.ccfs2_value >= cap.center_seg0) ? cap.ccfs2_value - cap.center_seg0
                                                     : cap.center_seg0 - cap.ccfs2_value;
      ccf160  = (nss_map == 4'd1) || (nss_map == 4'd2) || (nss_map == 4'd3);
      ccf8080 = (nss_map == 4'd5) || (nss_map == 4'd2) || (nss_map == 4'd6) ||
                (nss_map == 4'd3);
      priority if ((rev && d_seg == SPAN_160) || (ccf160 && ccf && d_ccf == SPAN_160))
         promo_cw = CW_160;
      else if ((rev && d_seg > SPAN_80P80) || (ccf8080 && ccf && d_ccf > SPAN_80P80))
         promo_cw = CW_80P80;
      else
         promo_cw = CW_80;
   end

   assign chan_width = (mode_seen[1] && base_cw == CW_80) ? promo_cw : base_cw;

endmodule

// ===== design/wlan_ie_channel_width_parser_top.sv =====
// Top level of the information-element channel-width parser.
// Depends on wiecw_pkg, wiecw_tracker, wiecw_decide and assert_macros.svh.
//
//   port group | dir | carries
//   req_*      | in  | one element-list byte per request, tlast on final byte
//   rsp_*      | out | channel width and mode, one request per list
//
// One byte per cycle unless a last byte is stalled: input register, walker/decision
// logic, result register. A list's result registers as its last byte advances.
// Reset is synchronous and returns the walker to the start of an element.
// A waiting result stalls only a last byte; other bytes keep flowing.
module wlan_ie_channel_width_parser_top
   import wiecw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ie_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] chan_width, [4:3] mode_seen, [7:5] zero
);

   `include "assert_macros.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_cw_ff;
   logic [1:0] rsp_mode_ff;
   logic       advance;
   cap_type    cap_next;
   logic [2:0] chan_width;
   logic [1:0] mode_seen;

   assign advance     = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   wiecw_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .ie_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .cap_next  (cap_next)
   );

   wiecw_decide u_decide (
      .cap        (cap_next),
      .chan_width (chan_width),
      .mode_seen  (mode_seen)
   );

   always_comb begin
      priority if (advance && in_last_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_cw_ff   <= chan_width;
         rsp_mode_ff <= mode_seen;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_mode_ff, rsp_cw_ff};

   `ASSERT_NEVER(a_cw_range, clock, reset, rsp_tvalid && rsp_tdata[2:0] == 3'd7)
   `ASSERT_CLK(a_none_is_20, clock, reset,
      rsp_tvalid && rsp_tdata[4:3] == MODE_NONE |-> rsp_tdata[2:0] == CW_20)
   `ASSERT_CLK(a_ht_le_40, clock, reset,
      rsp_tvalid && rsp_tdata[4:3] == MODE_HT |-> !rsp_tdata[2])
   `ASSERT_CLK(a_last_held, clock, reset,
      in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready |=> in_valid_ff && in_last_ff)

endmodule
